### hw/rtl/plst_pkg.sv
package plst_pkg;

  // Table geometry and field widths used inside the block.
  localparam int unsigned PEER_ID_WIDTH = 8;
  localparam int unsigned SEQ_WIDTH     = 32;
  localparam int unsigned TIME_WIDTH    = 32;
  localparam int unsigned DEPTH         = 1 << PEER_ID_WIDTH;
  localparam int unsigned COUNT_W       = PEER_ID_WIDTH + 1;

  // Port widths fixed by the interface.
  localparam int unsigned ID_IN_W     = 8;
  localparam int unsigned SEQ_IN_W    = 32;
  localparam int unsigned TIME_IN_W   = 32;
  localparam int unsigned COUNT_OUT_W = 9;
  localparam int unsigned CFG_W       = 32;
  localparam int unsigned CFG_IDX_W   = 2;

  // Sequence plus threshold is summed one bit wider so it never wraps.
  localparam int unsigned SUM_W = ((SEQ_WIDTH > CFG_W) ? SEQ_WIDTH : CFG_W) + 1;
  // Silence and timeout are compared at the wider of the two widths.
  localparam int unsigned CMP_W = (TIME_WIDTH > CFG_W) ? TIME_WIDTH : CFG_W;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_RESTART = CFG_IDX_W'(1);

  // Item kinds.
  typedef enum logic [1:0] {
    KIND_HEARTBEAT = 2'd0,
    KIND_TELEMETRY = 2'd1,
    KIND_REFRESH   = 2'd2,
    KIND_QUERY     = 2'd3
  } kind_e;

  // One table entry held in the memory.
  typedef struct packed {
    logic [SEQ_WIDTH-1:0]  seq;
    logic [TIME_WIDTH-1:0] stamp;
  } entry_t;

  // Memory port request from the controller.
  typedef struct packed {
    logic                     we;
    logic [PEER_ID_WIDTH-1:0] waddr;
    entry_t                   wdata;
    logic [PEER_ID_WIDTH-1:0] raddr;
  } ram_req_t;

  // Finished result handed to the output register.
  typedef struct packed {
    logic               accepted;
    logic               new_stream;
    logic               peer_online;
    logic [COUNT_W-1:0] known_cnt;
    logic [COUNT_W-1:0] online_cnt;
  } result_t;

  // Configuration register values.
  typedef struct packed {
    logic [CFG_W-1:0] timeout;
    logic [CFG_W-1:0] restart;
  } cfg_t;

endpackage

### hw/rtl/peer_liveness_seq_table_unit.sv
// Channel  | Handshake                 | Payload
// ---------+---------------------------+--------------------------------------------
// input    | in_valid_i / in_stall_o   | kind_i, peer_id_i, seq_number_i, now_ms_i
// output   | out_valid_o / out_stall_i | accepted_o, new_stream_o, peer_online_o,
//          |                           | known_count_o, online_count_o
// config   | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
//
// Heartbeat, telemetry and query items first read the entry memory, then, once the output
// register is free, write the entry back (heartbeat and telemetry only) and load the result register.
// A refresh item walks the entry memory one entry a cycle.
// Reset clears the known and online marks and totals at once; no clearing pass.
// A stalled result holds in the output register; the next item is taken meanwhile
// and finishes once the register frees.
module peer_liveness_seq_table_unit
  import plst_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [1:0]             kind_i,
  input  logic [ID_IN_W-1:0]     peer_id_i,
  input  logic [SEQ_IN_W-1:0]    seq_number_i,
  input  logic [TIME_IN_W-1:0]   now_ms_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic                   accepted_o,
  output logic                   new_stream_o,
  output logic                   peer_online_o,
  output logic [COUNT_OUT_W-1:0] known_count_o,
  output logic [COUNT_OUT_W-1:0] online_count_o,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [CFG_W-1:0]       cfg_data_i
);

  cfg_t     cfg_q;
  ram_req_t ram_req;
  entry_t   rd_data;
  result_t  res, res_q;
  logic     res_valid, out_valid_q, out_free;

  // Configuration registers; writes are always taken.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.timeout <= CFG_W'(1000);
      cfg_q.restart <= CFG_W'(1000);
    end else if (cfg_valid_i) begin
      if (cfg_index_i == CFG_TIMEOUT) begin
        cfg_q.timeout <= cfg_data_i;
      end
      if (cfg_index_i == CFG_RESTART) begin
        cfg_q.restart <= cfg_data_i;
      end
    end
  end

  plst_ram u_ram (
    .clk_i     (clk_i),
    .req_i     (ram_req),
    .rd_data_o (rd_data)
  );

  plst_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .kind_i      (kind_e'(kind_i)),
    .peer_id_i   (PEER_ID_WIDTH'(peer_id_i)),
    .seq_i       (SEQ_WIDTH'(seq_number_i)),
    .now_i       (TIME_WIDTH'(now_ms_i)),
    .cfg_i       (cfg_q),
    .out_free_i  (out_free),
    .res_valid_o (res_valid),
    .res_o       (res),
    .ram_req_o   (ram_req),
    .rd_data_i   (rd_data)
  );

  // Output register between the table and the consumer.
  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      res_q <= res;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign accepted_o     = res_q.accepted;
  assign new_stream_o   = res_q.new_stream;
  assign peer_online_o  = res_q.peer_online;
  assign known_count_o  = COUNT_OUT_W'(res_q.known_cnt);
  assign online_count_o = COUNT_OUT_W'(res_q.online_cnt);

endmodule

### hw/rtl/plst_ram.sv
module plst_ram
  import plst_pkg::*;
(
  input  logic     clk_i,
  input  ram_req_t req_i,
  output entry_t   rd_data_o
);

  entry_t mem_q [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
    rd_data_o <= mem_q[req_i.raddr];
  end

endmodule

### hw/rtl/plst_ctrl.sv
module plst_ctrl
  import plst_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  kind_e                    kind_i,
  input  logic [PEER_ID_WIDTH-1:0] peer_id_i,
  input  logic [SEQ_WIDTH-1:0]     seq_i,
  input  logic [TIME_WIDTH-1:0]    now_i,
  input  cfg_t                     cfg_i,
  input  logic                     out_free_i,
  output logic                     res_valid_o,
  output result_t                  res_o,
  output ram_req_t                 ram_req_o,
  input  entry_t                   rd_data_i
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_EXEC  = 4'b0010,
    ST_SWEEP = 4'b0100,
    ST_FIN   = 4'b1000
  } state_e;

  state_e                   state_q, state_d;
  kind_e                    kind_q;
  logic [PEER_ID_WIDTH-1:0] id_q;
  logic [SEQ_WIDTH-1:0]     seq_q;
  logic [TIME_WIDTH-1:0]    now_q;
  logic [COUNT_W-1:0]       cnt_q, cnt_d;
  logic                     chk_v_q, chk_v_d;
  logic [PEER_ID_WIDTH-1:0] chk_idx_q;
  logic [DEPTH-1:0]         known_q, online_q;
  logic [COUNT_W-1:0]       known_total_q, online_total_q;
  logic [COUNT_W-1:0]       known_next, online_next;

  logic                     accept, exec_go, is_hb, is_tel;
  logic                     cur_known, cur_online;
  logic [SUM_W-1:0]         seq_sum;
  logic                     restart;
  logic [SEQ_WIDTH-1:0]     seq_eff;
  logic                     tel_ok, fresh;
  logic                     set_known, set_online, expire;
  logic [TIME_WIDTH-1:0]    silence;

  assign accept     = (state_q == ST_IDLE) && in_valid_i;
  assign in_stall_o = (state_q != ST_IDLE);
  assign exec_go    = (state_q == ST_EXEC) && out_free_i;
  assign is_hb      = (kind_q == KIND_HEARTBEAT);
  assign is_tel     = (kind_q == KIND_TELEMETRY);
  assign cur_known  = known_q[id_q];
  assign cur_online = online_q[id_q];

  // Telemetry freshness check, with the restart rule applied first.
  assign seq_sum = SUM_W'(seq_q) + SUM_W'(cfg_i.restart);
  assign restart = seq_sum < SUM_W'(rd_data_i.seq);
  assign seq_eff = restart ? '0 : rd_data_i.seq;
  assign tel_ok  = is_tel && cur_known && (seq_q > seq_eff);
  assign fresh   = tel_ok && (seq_eff == '0);

  // Flag updates for the item in execution.
  assign set_known  = exec_go && is_hb && !cur_known;
  assign set_online = exec_go && (is_hb || tel_ok) && !cur_online;

  // Sweep check on the entry read in the previous cycle.
  assign silence = now_q - rd_data_i.stamp;
  assign expire  = chk_v_q && online_q[chk_idx_q] &&
                   (CMP_W'(silence) >= CMP_W'(cfg_i.timeout));

  assign known_next  = known_total_q + COUNT_W'(set_known);
  assign online_next = online_total_q + COUNT_W'(set_online) - COUNT_W'(expire);

  // Memory read address and write-back.
  always_comb begin
    ram_req_o.we          = exec_go && (is_hb || (is_tel && cur_known && (restart || tel_ok)));
    ram_req_o.waddr       = id_q;
    ram_req_o.wdata.stamp = (is_hb || tel_ok) ? now_q : rd_data_i.stamp;
    if (is_hb) begin
      ram_req_o.wdata.seq = cur_online ? rd_data_i.seq : '0;
    end else begin
      ram_req_o.wdata.seq = tel_ok ? seq_q : seq_eff;
    end
    unique case (state_q)
      ST_IDLE:  ram_req_o.raddr = peer_id_i;
      ST_SWEEP: ram_req_o.raddr = cnt_q[PEER_ID_WIDTH-1:0];
      default:  ram_req_o.raddr = id_q;
    endcase
  end

  // Result of the finishing item.
  always_comb begin
    res_valid_o       = exec_go || ((state_q == ST_FIN) && out_free_i);
    res_o.accepted    = (state_q == ST_EXEC) && tel_ok;
    res_o.new_stream  = (state_q == ST_EXEC) && fresh;
    res_o.peer_online = (state_q == ST_EXEC) ? (cur_online || is_hb || tel_ok)
                                             : online_q[id_q];
    res_o.known_cnt   = known_next;
    res_o.online_cnt  = online_next;
  end

  // Sequencer: execute, or sweep all entries and finish.
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    chk_v_d = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        cnt_d = '0;
        if (in_valid_i) begin
          state_d = (kind_i == KIND_REFRESH) ? ST_SWEEP : ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (out_free_i) begin
          state_d = ST_IDLE;
        end
      end
      ST_SWEEP: begin
        chk_v_d = !cnt_q[PEER_ID_WIDTH];
        if (!cnt_q[PEER_ID_WIDTH]) begin
          cnt_d = cnt_q + COUNT_W'(1);
        end else if (!chk_v_q) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_free_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control registers, flags and totals.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      cnt_q          <= '0;
      chk_v_q        <= 1'b0;
      known_q        <= '0;
      online_q       <= '0;
      known_total_q  <= '0;
      online_total_q <= '0;
    end else begin
      state_q        <= state_d;
      cnt_q          <= cnt_d;
      chk_v_q        <= chk_v_d;
      known_total_q  <= known_next;
      online_total_q <= online_next;
      if (set_known) begin
        known_q[id_q] <= 1'b1;
      end
      if (set_online) begin
        online_q[id_q] <= 1'b1;
      end
      if (expire) begin
        online_q[chk_idx_q] <= 1'b0;
      end
    end
  end

  // Item fields and sweep pipeline index.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q <= kind_i;
      id_q   <= peer_id_i;
      seq_q  <= seq_i;
      now_q  <= now_i;
    end
    chk_idx_q <= cnt_q[PEER_ID_WIDTH-1:0];
  end

`ifndef SYNTH
  a_online_le_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    online_total_q <= known_total_q)
    else $error("online total exceeds known total");

  a_write_in_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_req_o.we |-> (state_q == ST_EXEC))
    else $error("table write outside execution");

  a_refresh_sweeps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (kind_i == KIND_REFRESH)) |=> (state_q == ST_SWEEP))
    else $error("refresh item did not start a sweep");

  a_result_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> out_free_i)
    else $error("result issued into a full output register");
`endif

endmodule
